@@ rtl/core/ifcc_pkg.sv @@
package ifcc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_length;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } out_item_t;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic        crc_en;
    logic        rcrc_lo;
    logic        rcrc_hi;
    logic        last;
    logic        check_crc;
    logic [1:0]  pre_status;
    logic [15:0] length;
  } cmd_t;

  // one byte of crc-16, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/ifcc_front.sv @@
module ifcc_front #(
  parameter int unsigned MAX_PAYLOAD = ifcc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ifcc_pkg::in_item_t item,
  output ifcc_pkg::cmd_t    cmd
);
  import ifcc_pkg::*;

  localparam logic [15:0] POS_LEN_LO  = 16'd2;
  localparam logic [15:0] POS_LEN_HI  = 16'd3;
  localparam logic [15:0] POS_RCRC_LO = 16'd4;
  localparam logic [15:0] POS_RCRC_HI = 16'd5;
  localparam logic [15:0] HDR_BYTES   = 16'd4;
  localparam logic [16:0] PAY_OFFSET  = 17'd6;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] MAX_LEN     = 16'(MAX_PAYLOAD);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos;
  logic [15:0] len;
  logic [15:0] len_new;
  logic [15:0] count;
  logic [16:0] pay_end;
  logic        live;

  always_comb begin
    pos     = item.frame_start ? 16'h0000 : pos_r;
    len     = item.frame_start ? 16'h0000 : len_r;
    live    = (pos != POS_MAX);
    pay_end = {1'b0, len} + PAY_OFFSET;

    len_new = len;
    if (live && pos == POS_LEN_LO) begin
      len_new = {len[15:8], item.data_byte};
    end else if (live && pos == POS_LEN_HI) begin
      len_new = {item.data_byte, len[7:0]};
    end
    count = live ? pos + 16'd1 : pos;

    cmd           = '0;
    cmd.data_byte = item.data_byte;
    cmd.first     = (pos == 16'h0000);
    cmd.crc_en    = live && ((pos < HDR_BYTES) ||
                             (({1'b0, pos} >= PAY_OFFSET) && ({1'b0, pos} < pay_end)));
    cmd.rcrc_lo   = live && (pos == POS_RCRC_LO);
    cmd.rcrc_hi   = live && (pos == POS_RCRC_HI);
    cmd.last      = item.frame_end;
    cmd.length    = len_new;
    cmd.check_crc = 1'b0;
    if ({1'b0, count} < PAY_OFFSET) begin
      cmd.pre_status = ST_SHORT;
    end else if (len_new > MAX_LEN) begin
      cmd.pre_status = ST_TOO_LONG;
    end else if ({1'b0, count} < ({1'b0, len_new} + PAY_OFFSET)) begin
      cmd.pre_status = ST_SHORT;
    end else begin
      cmd.pre_status = ST_OK;
      cmd.check_crc  = 1'b1;
    end

    pos_nxt = pos_r;
    len_nxt = len_r;
    if (accept) begin
      if (item.frame_end) begin
        pos_nxt = 16'h0000;
        len_nxt = 16'h0000;
      end else begin
        pos_nxt = count;
        len_nxt = len_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 16'h0000;
      len_r <= 16'h0000;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

@@ rtl/core/ifcc_queue.sv @@
module ifcc_queue #(
  parameter int unsigned DEPTH = ifcc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ifcc_pkg::cmd_t push_data,
  input  logic           pop,
  output ifcc_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import ifcc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/ifcc_back.sv @@
module ifcc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ifcc_pkg::cmd_t      cmd,
  input  logic                cmd_avail,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ifcc_pkg::out_item_t out_data
);
  import ifcc_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] fcrc_r, fcrc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic [15:0] crc_base;
  logic [15:0] fcrc_base;

  assign cmd_pop   = cmd_avail && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    crc_base  = cmd.first ? 16'h0000 : crc_r;
    fcrc_base = cmd.first ? 16'h0000 : fcrc_r;
    crc_nxt   = cmd.crc_en ? crc_byte(crc_base, cmd.data_byte) : crc_base;
    fcrc_nxt  = fcrc_base;
    if (cmd.rcrc_lo) begin
      fcrc_nxt = {fcrc_base[15:8], cmd.data_byte};
    end else if (cmd.rcrc_hi) begin
      fcrc_nxt = {cmd.data_byte, fcrc_base[7:0]};
    end

    out_data_nxt                = out_data_r;
    out_data_nxt.payload_length = cmd.length;
    out_data_nxt.computed_crc   = crc_nxt;
    out_data_nxt.received_crc   = fcrc_nxt;
    if (cmd.check_crc) begin
      out_data_nxt.status = (crc_nxt != fcrc_nxt) ? ST_MISMATCH : ST_OK;
    end else begin
      out_data_nxt.status = cmd.pre_status;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd_pop && cmd.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 16'h0000;
      fcrc_r      <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        crc_r  <= crc_nxt;
        fcrc_r <= fcrc_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/imu_frame_crc_checker.sv @@
// frame crc checker: one byte per transaction, one result per frame-end byte
// throughput: one byte per cycle, set by bytewise crc step; a full queue stalls
// a frame-end byte goes via the queue and back end to the out_valid register
// the two-entry queue and the output register let input and output stall apart
// reset: synchronous active-low rst_n clears position, length, crc and all valids
module imu_frame_crc_checker #(
  parameter int unsigned MAX_PAYLOAD = ifcc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ifcc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ifcc_pkg::out_item_t out_data
);
  import ifcc_pkg::*;

  // front end: byte position and length field, classifies each byte
  cmd_t front_cmd;
  // queue head toward the crc back end
  cmd_t q_head;
  logic q_empty;
  logic q_full;
  logic q_pop;
  logic in_accept;

  // the front never stalls by itself, only on a full queue
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  ifcc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(in_accept),
    .item  (in_data),
    .cmd   (front_cmd)
  );

  // short queue between classification and crc accumulation
  ifcc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_data(front_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end: running crc, received crc, final status into the output register
  ifcc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (q_head),
    .cmd_avail(!q_empty),
    .cmd_pop  (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // an accepted byte is always waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !q_empty)
    else $error("accepted byte missing from queue");

  // an ok status only when the two crcs agree
  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK) |->
      (out_data.computed_crc == out_data.received_crc))
    else $error("ok status with differing crcs");

  // too long status only for a length above the limit
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_TOO_LONG) |->
      (out_data.payload_length > 16'(MAX_PAYLOAD)))
    else $error("too long status with length in range");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  import ifcc_pkg::*;

  // frame layout and limits
  localparam int unsigned PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
  localparam int          CRC_BYTES_END = 4;        // crc covers bytes 0..3 of the header
  localparam int          PAYLOAD_START = 6;        // payload begins after the received crc
  localparam logic [15:0] POS_SAT       = 16'hFFFF; // byte position stops counting here
  localparam int          RANDOM_BYTES  = 680;
  localparam int          DRAIN_LIMIT   = 5000;     // cycles allowed for results to drain

  // one byte waiting to be driven; tight keeps the gaps small
  typedef struct packed {
    in_item_t item;
    logic     tight;
  } pending_byte_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pending_byte_t byte_stream [$];     // bytes still to be driven
  out_item_t     frame_verdicts [$];  // predicted results, oldest first

  int   errors         = 0;
  int   total_bytes    = 0;
  int   accepted_bytes = 0;
  int   gap_left       = 0;
  int   stall_left     = 0;
  logic calm           = 1'b0;        // while set, neither side idles

  // predictor state, mirrors the frame tracking of the block
  logic [15:0] pos_q;
  logic [15:0] crc_acc;
  logic [15:0] len_seen;
  logic [15:0] rx_crc;

  imu_frame_crc_checker #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // crc-16 with poly 0x1021, one input bit at a time, msb first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // idle length for either side: mostly none or short, now and then long
  function automatic int idle_length(input logic tight);
    int r;
    r = $urandom_range(0, 99);
    if (calm) begin
      return 0;
    end
    if (tight) begin
      return (r < 80) ? 0 : $urandom_range(1, 2);
    end
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic clear_frame();
    pos_q    = '0;
    crc_acc  = '0;
    len_seen = '0;
    rx_crc   = '0;
  endtask

  // advance the frame tracking by one accepted byte, queue a verdict on an end mark
  task automatic track_byte(input in_item_t b);
    out_item_t v;
    if (b.frame_start) begin
      clear_frame();
    end
    if (pos_q != POS_SAT) begin
      if (int'(pos_q) < CRC_BYTES_END) begin
        crc_acc = crc16_step(crc_acc, b.data_byte);
      end
      case (pos_q)
        16'd2: len_seen[7:0]  = b.data_byte;
        16'd3: len_seen[15:8] = b.data_byte;
        16'd4: rx_crc[7:0]    = b.data_byte;
        16'd5: rx_crc[15:8]   = b.data_byte;
        default: begin
          // payload bytes only; anything past the length is trailing junk
          if (int'(pos_q) >= PAYLOAD_START &&
              int'(pos_q) - PAYLOAD_START < int'(len_seen)) begin
            crc_acc = crc16_step(crc_acc, b.data_byte);
          end
        end
      endcase
      pos_q = pos_q + 16'd1;
    end
    if (b.frame_end) begin
      if (int'(pos_q) < PAYLOAD_START) begin
        v.status = ST_SHORT;
      end else if (int'(len_seen) > int'(PAYLOAD_LIMIT)) begin
        v.status = ST_TOO_LONG;
      end else if (int'(pos_q) < PAYLOAD_START + int'(len_seen)) begin
        v.status = ST_SHORT;
      end else if (crc_acc != rx_crc) begin
        v.status = ST_MISMATCH;
      end else begin
        v.status = ST_OK;
      end
      v.payload_length = len_seen;
      v.computed_crc   = crc_acc;
      v.received_crc   = rx_crc;
      frame_verdicts.push_back(v);
      clear_frame();
    end
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic s, input logic e,
                            input logic tight);
    pending_byte_t p;
    p.item.data_byte   = d;
    p.item.frame_start = s;
    p.item.frame_end   = e;
    p.tight            = tight;
    byte_stream.push_back(p);
  endtask

  // build a frame with the given length field and send its first total bytes;
  // fill < 0 gives random content, otherwise every free byte holds fill
  task automatic queue_frame(input logic [15:0] len, input int total, input bit good,
                             input bit mark_start, input bit mark_end, input int fill,
                             input bit tight);
    logic [7:0]  body [$];
    logic [15:0] crc;
    int          covered;
    int          span;
    body = {};
    span = (total > PAYLOAD_START) ? total : PAYLOAD_START;
    for (int i = 0; i < span; i++) begin
      body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    body[2] = len[7:0];
    body[3] = len[15:8];
    crc = '0;
    for (int i = 0; i < CRC_BYTES_END; i++) begin
      crc = crc16_step(crc, body[i]);
    end
    covered = total - PAYLOAD_START;
    if (covered < 0) begin
      covered = 0;
    end
    if (covered > int'(len)) begin
      covered = int'(len);
    end
    for (int i = 0; i < covered; i++) begin
      crc = crc16_step(crc, body[PAYLOAD_START + i]);
    end
    if (!good) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    body[4] = crc[7:0];
    body[5] = crc[15:8];
    for (int i = 0; i < total; i++) begin
      queue_byte(body[i], mark_start && (i == 0), mark_end && (i == total - 1), tight);
    end
  endtask

  // random traffic: mostly well-formed frames, the rest broken frames and noise
  task automatic queue_random_traffic();
    int          mark;
    int          sent;
    int          kind;
    int          n;
    logic [15:0] len;
    bit          s;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      mark = byte_stream.size();
      kind = $urandom_range(0, 99);
      s    = ($urandom_range(0, 9) != 0);
      len  = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(100, PAYLOAD_LIMIT))
                                          : 16'($urandom_range(0, 40));
      if (kind < 60) begin
        // well-formed, mostly with a good crc
        queue_frame(len, PAYLOAD_START + int'(len), $urandom_range(0, 9) != 0, s, 1, -1, 0);
      end else if (kind < 70) begin
        queue_frame(len, PAYLOAD_START + int'(len), 0, s, 1, -1, 0);
      end else if (kind < 78) begin
        // payload cut off before the length is reached
        len = 16'($urandom_range(1, 40));
        queue_frame(len, $urandom_range(1, PAYLOAD_START - 1 + int'(len)), 1, s, 1, -1, 0);
      end else if (kind < 83) begin
        // header never completes
        queue_frame(16'($urandom), $urandom_range(1, PAYLOAD_START - 1), 1, s, 1, -1, 0);
      end else if (kind < 88) begin
        len = 16'($urandom_range(PAYLOAD_LIMIT + 1, 65535));
        queue_frame(len, $urandom_range(PAYLOAD_START, 24), 1, s, 1, -1, 0);
      end else if (kind < 93) begin
        // trailing bytes after the payload
        queue_frame(len, PAYLOAD_START + int'(len) + $urandom_range(1, 8),
                    $urandom_range(0, 4) != 0, s, 1, -1, 0);
      end else if (kind < 97) begin
        // abandoned frame with no end mark
        queue_frame(len, $urandom_range(1, PAYLOAD_START + int'(len)), 1, s, 0, -1, 0);
      end else begin
        // loose bytes with random marks
        n = $urandom_range(1, 8);
        repeat (n) begin
          queue_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 0);
        end
      end
      sent += byte_stream.size() - mark;
    end
  endtask

  // quiet stretches for both sides
  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) begin
      calm <= ~calm;
    end
  end

  // driver: presents one byte per transaction, idles between them at random
  always @(posedge clk) begin
    pending_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_byte(in_data);
        accepted_bytes++;
      end
      // the payload may only change once the current byte is taken
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          nxt = byte_stream.pop_front();
          in_data  <= nxt.item;
          in_valid <= 1'b1;
          gap_left = idle_length(nxt.tight);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: stalls the result side at random, checks each result transaction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_verdicts.size() == 0) begin
          report_mismatch("result with nothing expected, status", out_data.status, 0);
        end else begin
          want = frame_verdicts.pop_front();
          if (out_data.status != want.status) begin
            report_mismatch("status", out_data.status, want.status);
          end
          if (out_data.payload_length != want.payload_length) begin
            report_mismatch("payload_length", out_data.payload_length, want.payload_length);
          end
          if (out_data.computed_crc != want.computed_crc) begin
            report_mismatch("computed_crc", out_data.computed_crc, want.computed_crc);
          end
          if (out_data.received_crc != want.received_crc) begin
            report_mismatch("received_crc", out_data.received_crc, want.received_crc);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? idle_length(1'b0) : 0;
      end
    end
  end

  initial begin
    int spin;
    clear_frame();

    // directed frames
    queue_byte(8'($urandom), 1, 1, 0);                          // one-byte frame
    queue_frame(16'd3, 5, 1, 1, 1, -1, 0);                      // header incomplete
    queue_frame(16'd0, 6, 1, 1, 1, 8'h00, 0);                   // all zero, empty payload
    queue_frame(16'hFFFF, 6, 1, 1, 1, 8'hFF, 0);                // ones fill, too long
    queue_frame(16'd0, 6, 0, 1, 1, -1, 0);                      // crc mismatch
    queue_frame(16'(PAYLOAD_LIMIT), PAYLOAD_START + PAYLOAD_LIMIT, 1, 1, 1, -1, 0);
    queue_frame(16'(PAYLOAD_LIMIT + 1), 12, 1, 1, 1, -1, 0);    // one over the limit
    queue_frame(16'd8, 10, 1, 1, 1, -1, 0);                     // payload cut short
    queue_frame(16'd4, 14, 1, 1, 1, -1, 0);                     // trailing bytes
    queue_frame(16'd5, 11, 1, 0, 1, -1, 0);                     // no start after an end
    queue_frame(16'd6, 9, 1, 1, 0, -1, 0);                      // abandoned, then restart
    queue_frame(16'd3, 9, 1, 1, 1, -1, 0);
    queue_frame(16'd2, 4, 1, 1, 0, -1, 0);                      // partial, then start+end
    queue_byte(8'($urandom), 1, 1, 0);
    queue_frame(16'd1, 7, 0, 0, 1, -1, 0);                      // mismatch, no start mark

    queue_random_traffic();
    total_bytes = byte_stream.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // all bytes taken, then results drain, then a wait for strays
    while (accepted_bytes < total_bytes) @(posedge clk);
    spin = 0;
    while (frame_verdicts.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);
    if (frame_verdicts.size() != 0) begin
      report_mismatch("results never arrived, count", 0, frame_verdicts.size());
    end

    if (errors == 0) begin
      $display("imu_frame_crc_checker test passed");
    end else begin
      $display("imu_frame_crc_checker test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("imu_frame_crc_checker test failed");
    $finish;
  end

endmodule
